// ===== design/windowed_min_parabolic_peak_macros.svh =====
// Assertion macros for the windowed minimum peak finder checker.
// Depends on signals named clk and rst in the scope of each use.
`ifndef WINDOWED_MIN_PARABOLIC_PEAK_MACROS_SVH
`define WINDOWED_MIN_PARABOLIC_PEAK_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WMPP_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define WMPP_ASSERT_NXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== design/wmpp_pkg.sv =====
// Shared types and constants for the windowed minimum peak finder.
// No dependencies; used by every module of the block.
package wmpp_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int IDX_W       = 12;
  localparam int FRAC_W      = 8;
  localparam int POS_W       = 21;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'b1;

  localparam logic [IDX_W-1:0] WINDOW_START_RESET = 12'd1;
  localparam logic [IDX_W-1:0] WINDOW_END_RESET   = 12'd4095;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]           peak_index;
    logic [POS_W-1:0]           peak_position;
    logic signed [SAMPLE_W-1:0] peak_value;
    logic                       degenerate;
  } out_item_t;

  // One finished trace: the minimum and its two neighbors.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_val;
    logic signed [SAMPLE_W-1:0] best_val;
    logic signed [SAMPLE_W-1:0] next_val;
    logic [IDX_W-1:0]           best_idx;
    logic                       degen;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_LOAD,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

// ===== design/wmpp_front.sv =====
// Front end: window registers, sample counter and minimum tracking.
// Depends on wmpp_pkg; pushes one job per trace into wmpp_queue.
module wmpp_front #(
  parameter int TRACE_LEN = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wmpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wmpp_pkg::in_item_t                in_data,
  output logic                              push,
  output wmpp_pkg::job_t                    push_data,
  input  wmpp_pkg::q_status_t               q_status
);

  localparam int IW = wmpp_pkg::IDX_W;
  localparam int SW = wmpp_pkg::SAMPLE_W;

  logic [IW-1:0]        window_start;
  logic [IW-1:0]        window_end;
  logic [IW-1:0]        sample_count;
  logic signed [SW-1:0] best_value;
  logic [IW-1:0]        best_index;
  logic signed [SW-1:0] previous_sample;
  logic signed [SW-1:0] before_best;
  logic signed [SW-1:0] after_best;
  logic                 after_pending;
  logic                 found_any;

  logic [IW-1:0]        sample_count_next;
  logic signed [SW-1:0] best_value_next;
  logic [IW-1:0]        best_index_next;
  logic signed [SW-1:0] before_best_next;
  logic signed [SW-1:0] after_best_next;
  logic                 after_pending_next;
  logic                 found_any_next;
  logic [31:0]          count_inc;
  logic                 in_win;
  logic                 take;
  logic                 accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_win = (sample_count >= window_start) && (sample_count < window_end);
    take   = in_win && (!found_any || (in_data.sample < best_value));

    best_value_next    = best_value;
    best_index_next    = best_index;
    before_best_next   = before_best;
    after_best_next    = after_best;
    after_pending_next = after_pending;
    found_any_next     = found_any;
    if (take) begin
      best_value_next    = in_data.sample;
      best_index_next    = sample_count;
      before_best_next   = previous_sample;
      after_pending_next = 1'b1;
      found_any_next     = 1'b1;
    end else if (after_pending) begin
      after_best_next    = in_data.sample;
      after_pending_next = 1'b0;
    end

    count_inc = 32'(sample_count) + 32'd1;
    if (count_inc == 32'(TRACE_LEN)) begin
      sample_count_next = '0;
    end else begin
      sample_count_next = count_inc[IW-1:0];
    end

    push               = accept && in_data.last;
    push_data.prev_val = before_best_next;
    push_data.best_val = best_value_next;
    push_data.next_val = after_best_next;
    push_data.best_idx = best_index_next;
    push_data.degen    = !found_any_next || (best_index_next == '0) || after_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start    <= wmpp_pkg::WINDOW_START_RESET;
      window_end      <= wmpp_pkg::WINDOW_END_RESET;
      sample_count    <= '0;
      best_value      <= '0;
      best_index      <= '0;
      previous_sample <= '0;
      before_best     <= '0;
      after_best      <= '0;
      after_pending   <= 1'b0;
      found_any       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wmpp_pkg::REG_WINDOW_START) begin
          window_start <= cfg_data[IW-1:0];
        end else if (cfg_index == wmpp_pkg::REG_WINDOW_END) begin
          window_end <= cfg_data[IW-1:0];
        end
      end
      if (accept) begin
        if (in_data.last) begin
          // trace done: its job is in the queue, start over
          sample_count    <= '0;
          best_value      <= '0;
          best_index      <= '0;
          previous_sample <= '0;
          before_best     <= '0;
          after_best      <= '0;
          after_pending   <= 1'b0;
          found_any       <= 1'b0;
        end else begin
          sample_count    <= sample_count_next;
          best_value      <= best_value_next;
          best_index      <= best_index_next;
          previous_sample <= in_data.sample;
          before_best     <= before_best_next;
          after_best      <= after_best_next;
          after_pending   <= after_pending_next;
          found_any       <= found_any_next;
        end
      end
    end
  end

endmodule

// ===== design/wmpp_queue.sv =====
// Short job queue between the front end and the divider back end.
// Depends on wmpp_pkg for the job type and depth.
module wmpp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wmpp_pkg::job_t      push_data,
  input  logic                pop,
  output wmpp_pkg::job_t      pop_data,
  output wmpp_pkg::q_status_t status
);

  localparam int DEPTH = wmpp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wmpp_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else                        r = p + PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/wmpp_back.sv =====
// Back end: parabolic offset by restoring division, position and output register.
// Depends on wmpp_pkg; pops jobs from wmpp_queue.
module wmpp_back (
  input  logic                clk,
  input  logic                rst,
  input  wmpp_pkg::q_status_t q_status,
  output logic                pop,
  input  wmpp_pkg::job_t      pop_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wmpp_pkg::out_item_t out_data
);

  localparam int SW     = wmpp_pkg::SAMPLE_W;
  localparam int F      = wmpp_pkg::FRAC_W;
  localparam int PW     = wmpp_pkg::POS_W;
  localparam int DIFF_W = SW + 1;
  localparam int CURV_W = SW + 2;
  localparam int W      = SW + F + 6;
  localparam int QW     = F + 3;
  localparam int STEP_W = $clog2(QW);
  localparam logic [QW-1:0] LIM = QW'(1) << F;

  wmpp_pkg::back_state_t state, state_next;

  wmpp_pkg::job_t           job;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CURV_W-1:0] curv;
  logic                     neg;
  logic                     degen;
  logic [W-1:0]             rem;
  logic [W-1:0]             dsh;
  logic [QW-1:0]            quo;
  logic [STEP_W-1:0]        step;

  logic                     load_out;
  logic                     curv_zero;
  logic [W-1:0]             abs_diff;
  logic [W-1:0]             abs_den;
  logic [QW-1:0]            mag;
  logic signed [PW:0]       q_off;
  logic signed [PW:0]       pos_sum;
  logic [PW-1:0]            pos;

  always_ff @(posedge clk) begin
    if (rst) state <= wmpp_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    curv_zero  = (curv == '0);
    unique case (state)
      wmpp_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = wmpp_pkg::BK_PREP;
        end
      end
      wmpp_pkg::BK_PREP: state_next = wmpp_pkg::BK_LOAD;
      wmpp_pkg::BK_LOAD: begin
        if (job.degen || curv_zero) state_next = wmpp_pkg::BK_FIN;
        else                        state_next = wmpp_pkg::BK_DIV;
      end
      wmpp_pkg::BK_DIV: begin
        if (step == STEP_W'(QW - 1)) state_next = wmpp_pkg::BK_FIN;
      end
      wmpp_pkg::BK_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = wmpp_pkg::BK_IDLE;
        end
      end
      default: state_next = wmpp_pkg::BK_IDLE;
    endcase
  end

  // magnitudes of numerator and denominator, numerator scaled by 2^F
  always_comb begin
    abs_diff = W'($unsigned(diff[DIFF_W-1] ? -diff : diff)) << F;
    abs_den  = W'($unsigned(curv[CURV_W-1] ? -curv : curv)) << 1;
  end

  // clamp, apply sign, add to the integer index and clamp below zero
  always_comb begin
    mag = (quo > LIM) ? LIM : quo;
    if (degen)    q_off = '0;
    else if (neg) q_off = -$signed((PW+1)'(mag));
    else          q_off = $signed((PW+1)'(mag));
    pos_sum = $signed((PW+1)'(job.best_idx) << F) + q_off;
    pos     = pos_sum[PW] ? '0 : pos_sum[PW-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      wmpp_pkg::BK_IDLE: begin
        if (pop) job <= pop_data;
      end
      wmpp_pkg::BK_PREP: begin
        diff <= DIFF_W'(job.prev_val) - DIFF_W'(job.next_val);
        curv <= CURV_W'(job.prev_val) - (CURV_W'(job.best_val) <<< 1)
              + CURV_W'(job.next_val);
      end
      wmpp_pkg::BK_LOAD: begin
        degen <= job.degen || curv_zero;
        neg   <= diff[DIFF_W-1] ^ curv[CURV_W-1];
        // rounded quotient: (2|num| + |den|) / (2|den|)
        rem   <= (abs_diff << 1) + abs_den;
        dsh   <= (abs_den << 1) << (QW - 1);
        quo   <= '0;
        step  <= '0;
      end
      wmpp_pkg::BK_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        step <= step + STEP_W'(1);
      end
      wmpp_pkg::BK_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.peak_index    <= job.best_idx;
      out_data.peak_position <= pos;
      out_data.peak_value    <= job.best_val;
      out_data.degenerate    <= degen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/windowed_min_parabolic_peak.sv =====
// Windowed minimum search with three-point parabolic refinement, top level.
// Samples: one per cycle; in_stall rises only when two finished traces wait in the queue.
// Result: queue, then PREP, LOAD, DIV (skipped if degenerate), FIN and output register.
// The back end takes one trace at a time (11-step restoring divider); traces arriving
// faster fill the two-entry queue and throttle input. Synchronous reset sets the
// window to 1..4094, clears trace state, queue and output valid; no clearing pass.
module windowed_min_parabolic_peak #(
  parameter int TRACE_LEN = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wmpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmpp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wmpp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wmpp_pkg::out_item_t             out_data
);

  logic                push;
  wmpp_pkg::job_t      push_data;
  logic                pop;
  wmpp_pkg::job_t      pop_data;
  wmpp_pkg::q_status_t q_status;

  // Front end: count samples, track the earliest minimum inside the window and
  // its neighbors; on the last beat of a trace, hand a job to the queue.
  wmpp_front #(
    .TRACE_LEN (TRACE_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_status  (q_status)
  );

  // Queue: hold finished traces so the next trace streams while one divides.
  wmpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Back end: form numerator and denominator, divide one bit a cycle, clamp
  // the offset to one sample and drive the output register.
  wmpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/wmpp_checker.sv =====
// Port-level checks on the result channel of the peak finder, bound to the top level.
// Depends on wmpp_pkg and windowed_min_parabolic_peak_macros.svh.
`include "windowed_min_parabolic_peak_macros.svh"

module wmpp_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input wmpp_pkg::out_item_t out_data
);

  localparam int F  = wmpp_pkg::FRAC_W;
  localparam int IW = wmpp_pkg::IDX_W;
  localparam int PW = wmpp_pkg::POS_W;

  `WMPP_ASSERT_NXT(a_valid_holds, out_valid && out_stall, out_valid, "result beat dropped")
  `WMPP_ASSERT_NXT(a_data_holds, out_valid && out_stall, $stable(out_data), "result changed")
  `WMPP_ASSERT_IMP(a_refine_idx, out_valid && !out_data.degenerate, out_data.peak_index != '0, "refined at index zero")
  `WMPP_ASSERT_IMP(a_degen_pos, out_valid && out_data.degenerate, (out_data.peak_position[F-1:0] == '0) && (out_data.peak_position[IW+F-1:F] == out_data.peak_index) && !out_data.peak_position[PW-1], "degenerate position off index")

endmodule

bind windowed_min_parabolic_peak wmpp_checker u_wmpp_checker (.*);
